// ===== design/csi_parameter_parser_macros.svh =====
// assertion macros shared by the parameter parser checkers
// no dependencies; included by the port monitor
`ifndef CSI_PARAMETER_PARSER_MACROS_SVH
`define CSI_PARAMETER_PARSER_MACROS_SVH

// clocked assertion, off while reset is high
`define CSI_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// clocked assertion that also holds through reset
`define CSI_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== design/cpp_pkg.sv =====
// shared types and constants of the csi parameter parser
// no dependencies; used by the front, queue and back modules
package cpp_pkg;

   localparam int INDEX_W   = 7;
   localparam int VALUE_W   = 32;
   localparam int COUNT_W   = 8;
   localparam int REQ_DATA_W = 48;
   localparam int RSP_DATA_W = 40;

   localparam logic [7:0] CHAR_ZERO = 8'h30;
   localparam logic [7:0] CHAR_NINE = 8'h39;
   localparam logic [7:0] CHAR_SEMI = 8'h3B;

   localparam logic [VALUE_W-1:0] EMPTY_VALUE = 32'hFFFF_FFFF;
   localparam logic [35:0]        INT32_TOP   = 36'h0_7FFF_FFFF;

   typedef enum logic [1:0] {
      ACT_CHAR  = 2'd0,
      ACT_CLEAR = 2'd1,
      ACT_QUERY = 2'd2,
      ACT_NONE  = 2'd3
   } action_type;

   typedef enum logic [2:0] {
      KIND_DIGIT = 3'd0,
      KIND_SEMI  = 3'd1,
      KIND_CLEAR = 3'd2,
      KIND_QUERY = 3'd3,
      KIND_NOP   = 3'd4
   } kind_type;

   typedef struct packed {
      kind_type             kind;
      logic [3:0]           digit;
      logic [INDEX_W-1:0]   index;
      logic [VALUE_W-1:0]   dflt;
   } item_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

endpackage

// ===== design/cpp_front.sv =====
// front end: takes request beats and classifies them into queue items
// depends on cpp_pkg
module cpp_front (
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [cpp_pkg::REQ_DATA_W-1:0]   req_tdata,
   input  logic [1:0]                       req_tuser,
   input  cpp_pkg::queue_status_type        queue_status,
   output logic                             push,
   output cpp_pkg::item_type                push_item
);

   logic [7:0]           ch;
   logic                 is_digit;
   cpp_pkg::action_type  action;

   assign ch       = req_tdata[7:0];
   assign action   = cpp_pkg::action_type'(req_tuser);
   assign is_digit = (ch >= cpp_pkg::CHAR_ZERO) && (ch <= cpp_pkg::CHAR_NINE);

   assign req_tready = !queue_status.full;
   assign push       = req_tvalid && !queue_status.full;

   always_comb begin
      push_item.digit = 4'(ch - cpp_pkg::CHAR_ZERO);
      push_item.index = req_tdata[14:8];
      push_item.dflt  = req_tdata[46:15];
      unique case (action)
         cpp_pkg::ACT_CHAR: begin
            if (is_digit) begin
               push_item.kind = cpp_pkg::KIND_DIGIT;
            end else if (ch == cpp_pkg::CHAR_SEMI) begin
               push_item.kind = cpp_pkg::KIND_SEMI;
            end else begin
               push_item.kind = cpp_pkg::KIND_NOP;
            end
         end
         cpp_pkg::ACT_CLEAR: push_item.kind = cpp_pkg::KIND_CLEAR;
         cpp_pkg::ACT_QUERY: push_item.kind = cpp_pkg::KIND_QUERY;
         cpp_pkg::ACT_NONE:  push_item.kind = cpp_pkg::KIND_NOP;
      endcase
   end

endmodule

// ===== design/cpp_queue.sv =====
// two-entry queue between the front end and the back end
// depends on cpp_pkg
module cpp_queue (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  cpp_pkg::item_type          push_item,
   input  logic                       pop,
   output cpp_pkg::item_type          pop_item,
   output cpp_pkg::queue_status_type  queue_status
);

   cpp_pkg::item_type  slot_ff [2];
   logic               wr_ptr_ff, wr_ptr_in;
   logic               rd_ptr_ff, rd_ptr_in;
   logic [1:0]         count_ff, count_in;

   assign pop_item           = slot_ff[rd_ptr_ff];
   assign queue_status.full  = (count_ff == 2'd2);
   assign queue_status.empty = (count_ff == 2'd0);

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop  ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

// ===== design/cpp_back.sv =====
// back end: segment state, parameter store and registered response beat
// depends on cpp_pkg
module cpp_back #(
   parameter int MAX_CHARS  = 100,
   parameter int MAX_PARAMS = 128
) (
   input  logic                             clock,
   input  logic                             reset,
   input  cpp_pkg::queue_status_type        queue_status,
   input  cpp_pkg::item_type                pop_item,
   output logic                             pop,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [cpp_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   output logic [0:0]                       rsp_tuser
);

   localparam int AW    = (MAX_PARAMS > 1) ? $clog2(MAX_PARAMS) : 1;
   localparam int CNT_W = $clog2(MAX_PARAMS + 1);
   localparam int CC_W  = $clog2(MAX_CHARS + 1);
   localparam int IW    = cpp_pkg::INDEX_W;
   localparam int WW    = (CNT_W > IW) ? CNT_W : IW;
   localparam int TW    = (CNT_W + 1 > 9) ? CNT_W + 1 : 9;
   localparam int VW    = cpp_pkg::VALUE_W;

   // segment state
   logic [CC_W-1:0]   char_count_ff, char_count_in;
   logic [VW-1:0]     acc_ff, acc_in;
   logic              has_digit_ff, has_digit_in;
   logic              ovf_ff, ovf_in;
   logic [CNT_W-1:0]  closed_ff, closed_in;

   // parameter store
   logic [VW-1:0]     param_store_ff [MAX_PARAMS];
   logic [VW-1:0]     rd_data_ff;
   logic              wr_en, rd_en;
   logic [AW-1:0]     wr_addr, rd_addr;

   // response stage
   logic              out_valid_ff, out_valid_in;
   logic              out_handled_ff, out_handled_in;
   logic [7:0]        out_count_ff, out_count_in;
   logic              out_query_ff, out_query_in;
   logic              out_use_mem_ff, out_use_mem_in;
   logic              out_found_ff, out_found_in;
   logic [VW-1:0]     out_alt_ff, out_alt_in;
   logic [VW-1:0]     out_dflt_ff;

   logic              room;
   logic              store_room;
   logic [35:0]       acc_next;
   logic [VW-1:0]     open_value;
   logic [WW-1:0]     idx_ext;
   logic [WW-1:0]     closed_ext;
   logic [TW-1:0]     total;
   logic [VW-1:0]     pick;
   logic [VW-1:0]     value;

   assign pop = !queue_status.empty && (!out_valid_ff || rsp_tready);

   assign room       = char_count_ff < CC_W'(MAX_CHARS);
   assign store_room = closed_ff < CNT_W'(MAX_PARAMS);
   assign acc_next   = 36'({acc_ff, 3'b000}) + 36'({acc_ff, 1'b0}) + 36'(pop_item.digit);
   assign open_value = has_digit_ff ? acc_ff : cpp_pkg::EMPTY_VALUE;
   assign idx_ext    = WW'(pop_item.index);
   assign closed_ext = WW'(closed_ff);

   assign wr_en   = pop && (pop_item.kind == cpp_pkg::KIND_SEMI) && room && !ovf_ff
                    && store_room;
   assign wr_addr = closed_ff[AW-1:0];
   assign rd_en   = pop && (pop_item.kind == cpp_pkg::KIND_QUERY);
   assign rd_addr = idx_ext[AW-1:0];

   always_comb begin
      char_count_in  = char_count_ff;
      acc_in         = acc_ff;
      has_digit_in   = has_digit_ff;
      ovf_in         = ovf_ff;
      closed_in      = closed_ff;
      out_handled_in = 1'b0;
      out_query_in   = 1'b0;
      out_use_mem_in = 1'b0;
      out_found_in   = 1'b0;
      out_alt_in     = open_value;
      unique case (pop_item.kind)
         cpp_pkg::KIND_DIGIT: begin
            if (room) begin
               char_count_in  = char_count_ff + CC_W'(1);
               out_handled_in = 1'b1;
               has_digit_in   = 1'b1;
               if (ovf_ff || (acc_next > cpp_pkg::INT32_TOP)) begin
                  ovf_in = 1'b1;
               end else begin
                  acc_in = acc_next[VW-1:0];
               end
            end
         end
         cpp_pkg::KIND_SEMI: begin
            if (room) begin
               char_count_in  = char_count_ff + CC_W'(1);
               out_handled_in = 1'b1;
               if (!ovf_ff && store_room) begin
                  closed_in = closed_ff + CNT_W'(1);
               end
               acc_in       = '0;
               has_digit_in = 1'b0;
               ovf_in       = 1'b0;
            end
         end
         cpp_pkg::KIND_CLEAR: begin
            char_count_in  = '0;
            acc_in         = '0;
            has_digit_in   = 1'b0;
            ovf_in         = 1'b0;
            closed_in      = '0;
            out_handled_in = 1'b1;
         end
         cpp_pkg::KIND_QUERY: begin
            out_query_in = 1'b1;
            if (idx_ext < closed_ext) begin
               out_use_mem_in = 1'b1;
               out_found_in   = 1'b1;
            end else if ((idx_ext == closed_ext) && store_room && !ovf_ff) begin
               out_found_in = 1'b1;
            end
         end
         cpp_pkg::KIND_NOP: begin
         end
         default: begin
         end
      endcase
   end

   // count after this beat, last open segment included
   always_comb begin
      total        = TW'(closed_in) + TW'(!ovf_in && (closed_in < CNT_W'(MAX_PARAMS)));
      out_count_in = (total > TW'(255)) ? 8'hFF : total[7:0];
      out_valid_in = pop ? 1'b1 : (out_valid_ff && !rsp_tready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         char_count_ff <= '0;
         acc_ff        <= '0;
         has_digit_ff  <= 1'b0;
         ovf_ff        <= 1'b0;
         closed_ff     <= '0;
         out_valid_ff  <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
         if (pop) begin
            char_count_ff <= char_count_in;
            acc_ff        <= acc_in;
            has_digit_ff  <= has_digit_in;
            ovf_ff        <= ovf_in;
            closed_ff     <= closed_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         out_handled_ff <= out_handled_in;
         out_count_ff   <= out_count_in;
         out_query_ff   <= out_query_in;
         out_use_mem_ff <= out_use_mem_in;
         out_found_ff   <= out_found_in;
         out_alt_ff     <= out_alt_in;
         out_dflt_ff    <= pop_item.dflt;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         param_store_ff[wr_addr] <= open_value;
      end
      if (rd_en) begin
         rd_data_ff <= param_store_ff[rd_addr];
      end
   end

   always_comb begin
      pick = out_use_mem_ff ? rd_data_ff : out_alt_ff;
      if (!out_query_ff) begin
         value = '0;
      end else if (out_found_ff && !pick[VW-1] && (pick != '0)) begin
         value = pick;
      end else begin
         value = out_dflt_ff;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {out_count_ff, value};
   assign rsp_tuser  = out_handled_ff;

endmodule

// ===== design/csi_parameter_parser.sv =====
// csi parameter parser, top level
// depends on cpp_pkg, cpp_front, cpp_queue and cpp_back
//
// usage:
//   req channel carries one beat per parameter character, clear or query;
//   the action code rides in req_tuser, the character, index and default in
//   req_tdata. rsp channel returns exactly one beat per request beat, in order,
//   with the handled flag in rsp_tuser and value and count in rsp_tdata.
// a taken request beat is stored in the queue, then popped into the response register.
// throughput: one beat per cycle while rsp_tready is high; the per-character
//   multiply-by-ten update and the single read port of the parameter store keep that rate.
// a two-entry queue sits between the classifier and the executing back end,
//   and the response register holds its beat while rsp_tready is low; once the
//   queue fills, req_tready drops until the receiver takes a beat.
// reset clears the segment state, the queue and the response register; the
//   parameter store is not cleared and only entries written since the last
//   clear are read back. req_tready is high the cycle after reset.
module csi_parameter_parser #(
   parameter int MAX_CHARS  = 100,
   parameter int MAX_PARAMS = 128
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [47:0]  req_tdata,   // ch[7:0], param_index[14:8], default_value[46:15]
   input  logic [1:0]   req_tuser,   // action[1:0]
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [39:0]  rsp_tdata,   // param_value[31:0], num_params[39:32]
   output logic [0:0]   rsp_tuser    // handled[0]
);

   cpp_pkg::queue_status_type  queue_status;
   cpp_pkg::item_type          push_item;
   cpp_pkg::item_type          pop_item;
   logic                       push;
   logic                       pop;

   cpp_front u_front (
      .req_tvalid   (req_tvalid),
      .req_tready   (req_tready),
      .req_tdata    (req_tdata),
      .req_tuser    (req_tuser),
      .queue_status (queue_status),
      .push         (push),
      .push_item    (push_item)
   );

   cpp_queue u_queue (
      .clock        (clock),
      .reset        (reset),
      .push         (push),
      .push_item    (push_item),
      .pop          (pop),
      .pop_item     (pop_item),
      .queue_status (queue_status)
   );

   cpp_back #(
      .MAX_CHARS  (MAX_CHARS),
      .MAX_PARAMS (MAX_PARAMS)
   ) u_back (
      .clock        (clock),
      .reset        (reset),
      .queue_status (queue_status),
      .pop_item     (pop_item),
      .pop          (pop),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_tready   (rsp_tready),
      .rsp_tdata    (rsp_tdata),
      .rsp_tuser    (rsp_tuser)
   );

endmodule

// ===== design/cpp_monitor.sv =====
// port monitor for the csi parameter parser, bound to the top level
// depends on csi_parameter_parser_macros.svh
`include "csi_parameter_parser_macros.svh"

module cpp_monitor #(
   parameter int MAX_PARAMS = 128
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   input  logic         req_tready,
   input  logic [47:0]  req_tdata,
   input  logic [1:0]   req_tuser,
   input  logic         rsp_tvalid,
   input  logic         rsp_tready,
   input  logic [39:0]  rsp_tdata,
   input  logic [0:0]   rsp_tuser
);

   logic [8:0] count_cap;

   assign count_cap = 9'(MAX_PARAMS);

   // stalled response beat holds
   `CSI_ASSERT(rsp_hold_a, clock, reset, rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser), "stalled response beat changed")

   // nothing pending right after reset and queue open
   `CSI_ASSERT_ALWAYS(reset_idle_a, clock, reset |=> !rsp_tvalid && req_tready, "block not idle after reset")

   // handled beats are characters or clears and carry a zero value
   `CSI_ASSERT(handled_zero_a, clock, reset, rsp_tvalid && rsp_tuser[0] |-> rsp_tdata[31:0] == 32'd0, "handled beat with nonzero value")

   // parameter count never exceeds the store depth
   `CSI_ASSERT(count_cap_a, clock, reset, rsp_tvalid |-> {1'b0, rsp_tdata[39:32]} <= count_cap, "parameter count above store depth")

endmodule

bind csi_parameter_parser cpp_monitor #(.MAX_PARAMS(MAX_PARAMS)) u_monitor (.*);
